FILE: design/alle_pkg.sv
package alle_pkg;

  // Request modes
  typedef enum logic [1:0] {
    MODE_INS_TAIL = 2'd0,
    MODE_INS_HEAD = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_READ     = 2'd3
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TWALK,
    S_RWALK,
    S_OWALK,
    S_RESP
  } state_e;

  localparam int unsigned DataW = 32;

endpackage

FILE: design/array_linked_list_engine_top.sv
// Request flow: insert at head, full store, or any request on an empty list goes straight
//   to the result. Tail insert and remove walk the list node by node, at most CAPACITY
//   nodes. Read out: elements follow one per cycle while the output is not stalled.
// Throughput: one request at a time, not ready while busy; a request holds the block until
//   its last result loads; output stalls hold the read out and the single result.
// Reset (rst_ni low, async): list empty, slot counter zero, output idle.
module array_linked_list_engine_top import alle_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              mode_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [DataW-1:0] data_o,
  output logic                    last_o
);

  // AW addresses a slot; IW also holds the "no node" code (== CAPACITY).
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NO_NODE = IW'(CAPACITY);
  localparam logic [AW-1:0] LAST_STEP = AW'(CAPACITY - 1);

  // ---------------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------------
  state_e                  state_q, state_d;
  logic [IW-1:0]           head_q, head_d;     // first node, NO_NODE when empty
  logic [IW-1:0]           free_q, free_d;     // next unused slot, only grows
  logic [IW-1:0]           cur_q, cur_d;       // node whose data sits in the read regs
  logic [IW-1:0]           prev_q, prev_d;     // predecessor during remove
  logic [IW-1:0]           idx_q, idx_d;       // slot taken by a tail insert
  logic [AW-1:0]           steps_q, steps_d;   // walk bound counter
  logic signed [DataW-1:0] val_q, val_d;       // request value
  status_e                 res_q, res_d;       // status for single-result requests

  // Output register: parts the result side from the walk
  logic                    out_vld_q, out_vld_d;
  status_e                 out_stat_q, out_stat_d;
  logic signed [DataW-1:0] out_data_q, out_data_d;
  logic                    out_last_q, out_last_d;

  // ---------------------------------------------------------------------------
  // Node store: one write port, one registered read port per array
  // ---------------------------------------------------------------------------
  logic signed [DataW-1:0] node_vals_q  [CAPACITY];
  logic [IW-1:0]           node_links_q [CAPACITY];
  logic signed [DataW-1:0] val_rd_q;
  logic [IW-1:0]           lnk_rd_q;

  logic                    vals_we, links_we;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic signed [DataW-1:0] wr_val;
  logic [IW-1:0]           wr_link;

  always_ff @(posedge clk_i) begin
    if (vals_we) begin
      node_vals_q[wr_addr] <= wr_val;
    end
    if (links_we) begin
      node_links_q[wr_addr] <= wr_link;
    end
    val_rd_q <= node_vals_q[rd_addr];
    lnk_rd_q <= node_links_q[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Shared conditions
  // ---------------------------------------------------------------------------
  logic in_acc, out_free, head_ok, lnk_ok, prev_ok, full, at_bound, hit, tail_brk;
  logic [IW-1:0] lnk_nx;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign head_ok    = (head_q < NO_NODE);
  assign lnk_ok     = (lnk_rd_q < NO_NODE);
  assign prev_ok    = (prev_q < NO_NODE);
  assign full       = (free_q >= NO_NODE);
  assign at_bound   = (steps_q == LAST_STEP);
  assign hit        = (val_rd_q == val_q);          // the one shared comparator
  assign tail_brk   = !lnk_ok || (lnk_rd_q == idx_q);
  assign lnk_nx     = lnk_ok ? lnk_rd_q : NO_NODE;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (mode_e'(mode_i))
            MODE_INS_TAIL: state_d = (!full && head_ok) ? S_TWALK : S_RESP;
            MODE_INS_HEAD: state_d = S_RESP;
            MODE_REMOVE:   state_d = head_ok ? S_RWALK : S_RESP;
            MODE_READ:     state_d = head_ok ? S_OWALK : S_RESP;
            default:       state_d = S_RESP;
          endcase
        end
      end
      S_TWALK: if (tail_brk || at_bound) state_d = S_RESP;
      S_RWALK: if (hit || !lnk_ok || at_bound) state_d = S_RESP;
      S_OWALK: if (out_free && (!lnk_ok || at_bound)) state_d = S_IDLE;
      S_RESP:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath, store access and result register
  // ---------------------------------------------------------------------------
  always_comb begin
    head_d     = head_q;
    free_d     = free_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    idx_d      = idx_q;
    steps_d    = steps_q;
    val_d      = val_q;
    res_d      = res_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_stat_d = out_stat_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    vals_we    = 1'b0;
    links_we   = 1'b0;
    wr_addr    = free_q[AW-1:0];
    wr_val     = value_i;
    wr_link    = NO_NODE;
    rd_addr    = cur_q[AW-1:0];    // re-read current node while stalled

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          val_d   = value_i;
          cur_d   = head_q;
          prev_d  = NO_NODE;
          steps_d = '0;
          rd_addr = head_q[AW-1:0];
          unique case (mode_e'(mode_i))
            MODE_INS_TAIL, MODE_INS_HEAD: begin
              if (full) begin
                res_d = STAT_FULL;
              end else begin
                res_d    = STAT_OK;
                vals_we  = 1'b1;
                links_we = 1'b1;
                idx_d    = free_q;
                free_d   = free_q + IW'(1);
                if (mode_e'(mode_i) == MODE_INS_HEAD) begin
                  wr_link = head_ok ? head_q : NO_NODE;
                  head_d  = free_q;
                end else if (!head_ok) begin
                  head_d = free_q;
                end
              end
            end
            MODE_REMOVE: res_d = STAT_NOT_FOUND;   // kept only if list empty
            MODE_READ:   res_d = STAT_EMPTY;
            default:     res_d = STAT_EMPTY;
          endcase
        end
      end

      S_TWALK: begin
        res_d = STAT_OK;
        if (tail_brk) begin
          links_we = 1'b1;
          wr_addr  = cur_q[AW-1:0];
          wr_link  = idx_q;
        end else if (at_bound) begin
          links_we = 1'b1;
          wr_addr  = lnk_rd_q[AW-1:0];
          wr_link  = idx_q;
        end else begin
          cur_d   = lnk_rd_q;
          steps_d = steps_q + AW'(1);
          rd_addr = lnk_rd_q[AW-1:0];
        end
      end

      S_RWALK: begin
        if (hit) begin
          res_d = STAT_OK;
          if (prev_ok) begin
            links_we = 1'b1;
            wr_addr  = prev_q[AW-1:0];
            wr_link  = lnk_nx;
          end else begin
            head_d = lnk_nx;
          end
        end else if (!lnk_ok || at_bound) begin
          res_d = STAT_NOT_FOUND;
        end else begin
          prev_d  = cur_q;
          cur_d   = lnk_rd_q;
          steps_d = steps_q + AW'(1);
          rd_addr = lnk_rd_q[AW-1:0];
        end
      end

      S_OWALK: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_stat_d = STAT_OK;
          out_data_d = val_rd_q;
          out_last_d = !lnk_ok || at_bound;
          if (lnk_ok && !at_bound) begin
            cur_d   = lnk_rd_q;
            steps_d = steps_q + AW'(1);
            rd_addr = lnk_rd_q[AW-1:0];
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_stat_d = res_q;
          out_data_d = '0;
          out_last_d = 1'b1;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= NO_NODE;
      free_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      free_q    <= free_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    idx_q      <= idx_d;
    steps_q    <= steps_d;
    val_q      <= val_d;
    res_q      <= res_d;
    out_stat_q <= out_stat_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = out_stat_q;
  assign data_o      = out_data_q;
  assign last_o      = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("engine took a transaction but did not go busy");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= NO_NODE)
    else $error("slot counter ran past capacity");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= NO_NODE)
    else $error("head index out of range");

  a_status_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_stat_q != STAT_OK)) |-> (out_last_q && (out_data_q == '0)))
    else $error("error result must be single, last, with zero data");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import alle_pkg::*;

  localparam int unsigned Capacity = 32;
  localparam int unsigned IdxW = $clog2(Capacity + 1);
  // Worst walk is Capacity nodes plus the response overhead.
  localparam int unsigned SettleCycles = 2 * Capacity + 8;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned RandomItems = 135;
  // Watchdog limit, well above the slowest legal run.
  localparam int unsigned CycleLimit = 400000;

  // One result transaction as the block should present it.
  typedef struct {
    status_e                 status;
    logic signed [DataW-1:0] data;
    logic                    last;
  } list_result_t;

  // Shadow copy of the node store; predicts the result transactions of each
  // accepted request and checks them in order as they leave the block.
  class list_scoreboard;
    logic signed [DataW-1:0] node_val [Capacity];
    logic [IdxW-1:0]         node_next [Capacity];
    logic [IdxW-1:0]         head;
    logic [IdxW-1:0]         used;
    list_result_t            expected_q [$];
    int                      errors;

    function new();
      head = IdxW'(Capacity);
      used = '0;
      errors = 0;
    endfunction

    function bit is_slot(logic [IdxW-1:0] idx);
      return idx < Capacity;
    endfunction

    function void push_result(status_e status, logic signed [DataW-1:0] data, logic last);
      list_result_t r;
      r.status = status;
      r.data = data;
      r.last = last;
      expected_q.push_back(r);
    endfunction

    function void note_request(mode_e mode, logic signed [DataW-1:0] value);
      logic [IdxW-1:0] cur;
      logic [IdxW-1:0] prv;
      logic [IdxW-1:0] nx;
      logic [IdxW-1:0] slot;
      int unsigned     steps;
      bit              done;
      case (mode)
        MODE_INS_TAIL, MODE_INS_HEAD: begin
          if (used >= Capacity) begin
            push_result(STAT_FULL, '0, 1'b1);
          end else begin
            slot = used;
            node_val[slot] = value;
            used = used + 1'b1;
            if (mode == MODE_INS_HEAD) begin
              node_next[slot] = is_slot(head) ? head : IdxW'(Capacity);
              head = slot;
            end else begin
              node_next[slot] = IdxW'(Capacity);
              if (!is_slot(head)) begin
                head = slot;
              end else begin
                cur = head;
                done = 1'b0;
                for (steps = 0; steps < Capacity && !done; steps++) begin
                  nx = node_next[cur];
                  if (!is_slot(nx) || nx == slot) done = 1'b1;
                  else cur = nx;
                end
                node_next[cur] = slot;
              end
            end
            push_result(STAT_OK, '0, 1'b1);
          end
        end
        MODE_REMOVE: begin
          cur = head;
          prv = IdxW'(Capacity);
          done = 1'b0;
          for (steps = 0; steps < Capacity && is_slot(cur) && !done; steps++) begin
            if (node_val[cur] == value) begin
              nx = is_slot(node_next[cur]) ? node_next[cur] : IdxW'(Capacity);
              if (!is_slot(prv)) head = nx;
              else node_next[prv] = nx;
              done = 1'b1;
            end else begin
              prv = cur;
              cur = node_next[cur];
            end
          end
          push_result(done ? STAT_OK : STAT_NOT_FOUND, '0, 1'b1);
        end
        default: begin
          if (!is_slot(head)) begin
            push_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            cur = head;
            for (steps = 0; steps < Capacity && is_slot(cur); steps++) begin
              push_result(STAT_OK, node_val[cur], 1'b0);
              cur = node_next[cur];
            end
            expected_q[$].last = 1'b1;
          end
        end
      endcase
    endfunction

    function void check_result(logic [1:0] status, logic signed [DataW-1:0] data,
                               logic last);
      list_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: status %0d data %0d last %0b",
                 $time, status, data, last);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (status !== exp_r.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, exp_r.status, status);
          errors++;
        end
        if (data !== exp_r.data) begin
          $display("%0t: data mismatch: expected %0d, actual %0d", $time, exp_r.data, data);
          errors++;
        end
        if (last !== exp_r.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b", $time, exp_r.last, last);
          errors++;
        end
      end
    endfunction

    function int list_len();
      logic [IdxW-1:0] cur;
      int              n;
      n = 0;
      cur = head;
      while (is_slot(cur) && n < Capacity) begin
        n++;
        cur = node_next[cur];
      end
      return n;
    endfunction

    // Value of a randomly chosen element currently in the list.
    function logic signed [DataW-1:0] pick_member();
      logic [IdxW-1:0] cur;
      int              k;
      k = $urandom_range(0, list_len() - 1);
      cur = head;
      repeat (k) cur = node_next[cur];
      return node_val[cur];
    endfunction

    function bit store_full();
      return used >= Capacity;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              mode_i;
  logic signed [DataW-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [1:0]              status_o;
  logic signed [DataW-1:0] data_o;
  logic                    last_o;

  list_scoreboard sb;
  bit             settle_phase = 1'b0;  // no idling on either side
  bit             hold_request = 1'b0;  // receiver: one long stall
  int unsigned    cycle_count = 0;

  array_linked_list_engine_top #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .data_o     (data_o),
    .last_o     (last_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Both monitors sample at the rising edge, before the block's registers move.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_request(mode_e'(mode_i), value_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(status_o, data_o, last_o);
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[array_linked_list_engine_top] ERROR");
    $finish;
  end

  // Receiver: random stall bursts, occasional long free runs, and one long
  // hold-off on request so the block backs up and stalls its input.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_request = 1'b0;
      end else if (!settle_phase) begin
        if ($urandom_range(0, 2) == 0) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 12)) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(10, 40)) @(negedge clk_i);
        end
      end
    end
  end

  // Offer one request transaction and hold it until accepted. Returns at the
  // falling edge after acceptance or a sender gap; with no gap valid stays high.
  task automatic send_request(input mode_e mode, input logic signed [DataW-1:0] value);
    in_valid_i <= 1'b1;
    mode_i <= mode;
    value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    // Sender gap: drop valid for a random burst, unless settling or under pressure.
    if (!settle_phase && !hold_request && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  // Mix of small values (duplicates), field extremes, and full-width noise.
  function automatic logic signed [DataW-1:0] random_value();
    case ($urandom_range(0, 7))
      0, 1: return $urandom_range(0, 7);
      2: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(DataW-1){1'b0}}};
          1: return {1'b0, {(DataW-1){1'b1}}};
          2: return '1;
          default: return '0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned             i;
    int unsigned             pick;
    logic signed [DataW-1:0] v;

    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    mode_i <= MODE_INS_TAIL;
    value_i <= '0;
    sb = new();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty-list cases first, then build a list that holds both
    // extremes and a duplicate, and take it apart from head, middle and tail.
    send_request(MODE_READ, 32'sd0);          // read out of empty list
    send_request(MODE_REMOVE, 32'sd5);        // remove on empty list
    send_request(MODE_INS_TAIL, 32'sh7FFF_FFFF); // tail insert into empty list
    send_request(MODE_INS_HEAD, 32'sh8000_0000);
    send_request(MODE_INS_TAIL, 32'sd0);
    send_request(MODE_INS_TAIL, -32'sd1);
    send_request(MODE_INS_HEAD, 32'sh5555_5555);
    send_request(MODE_INS_TAIL, 32'shAAAA_AAAA);
    send_request(MODE_INS_TAIL, 32'sd0);      // duplicate value at the tail
    send_request(MODE_READ, 32'sh1234_5678);  // value ignored on read out
    send_request(MODE_REMOVE, 32'sd0);        // first of two matches, mid-list
    send_request(MODE_REMOVE, 32'sh5555_5555); // head
    send_request(MODE_REMOVE, 32'sd0);        // tail
    send_request(MODE_REMOVE, 32'sh0000_1234); // absent value
    send_request(MODE_READ, '0);
    send_request(MODE_REMOVE, 32'sh8000_0000);
    send_request(MODE_REMOVE, 32'sh7FFF_FFFF);
    send_request(MODE_REMOVE, -32'sd1);
    send_request(MODE_REMOVE, 32'shAAAA_AAAA);
    send_request(MODE_READ, '0);              // emptied by removals
    send_request(MODE_INS_TAIL, 32'sd1);      // tail insert after the list drained
    send_request(MODE_READ, '0);

    // Random mix: inserts outweigh removes so the store fills, removes mostly
    // hit real members so the walks get deep.
    for (i = 0; i < RandomItems; i++) begin
      if (i == 10) hold_request = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_request(MODE_INS_TAIL, random_value());
      end else if (pick < 50) begin
        send_request(MODE_INS_HEAD, random_value());
      end else if (pick < 75) begin
        if (sb.list_len() > 0 && $urandom_range(0, 3) != 0) v = sb.pick_member();
        else v = random_value();
        send_request(MODE_REMOVE, v);
      end else begin
        send_request(MODE_READ, $urandom);
      end
    end

    // Closing stretch, no idling: fill the store, drain the list, then show
    // that an empty list with no free slots still refuses inserts.
    settle_phase = 1'b1;
    while (!sb.store_full()) send_request(MODE_INS_TAIL, random_value());
    send_request(MODE_READ, '0);
    while (sb.list_len() > 0) send_request(MODE_REMOVE, sb.pick_member());
    send_request(MODE_READ, '0);
    send_request(MODE_INS_HEAD, $urandom);
    send_request(MODE_INS_TAIL, $urandom);
    send_request(MODE_REMOVE, $urandom);
    in_valid_i <= 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[array_linked_list_engine_top] OK");
    end else begin
      $display("[array_linked_list_engine_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/alle_pkg.sv
design/array_linked_list_engine_top.sv
sim/testbench.sv
